FILE: rtl/rgb2yuv_pkg.sv
// shared types and constants for the rgb to yuv 4:2:0 converter
`timescale 1ns / 1ps

package rgb2yuv_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int DIM_W   = 13;  // configuration register width
   localparam int COUNT_W = 12;  // column and row counter width
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);
   localparam logic [DIM_W-1:0] STRIDE_RESET = DIM_W'(1920);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_ROW_STRIDE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] cb;
      logic [7:0] cr;
      logic       row_last;
      logic       frame_last;
   } yuv_type;

   // position flags of one source pixel, passed from the tracker to the datapath
   typedef struct packed {
      logic visible;
      logic chroma;
      logic row_last;
      logic frame_last;
   } pos_info_type;

endpackage

FILE: rtl/rgb2yuv_pos.sv
// configuration registers and raster position tracker
`timescale 1ns / 1ps

module rgb2yuv_pos
   import rgb2yuv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DIM_W-1:0]       csr_data,
   input  logic                   advance,
   output pos_info_type           pos_info
);

   localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_HEIGHT);
   localparam logic [DIM_W-1:0] ONE   = DIM_W'(1);

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [DIM_W-1:0]   stride_ff, stride_in;
   logic [COUNT_W-1:0] col_ff, col_in;
   logic [COUNT_W-1:0] row_ff, row_in;

   logic [DIM_W-1:0] w_eff, h_eff, st_clamp, st_eff;
   logic [DIM_W-1:0] col_ext, row_ext;
   logic             row_end, frame_end;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = ONE;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      stride_in = stride_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_in = csr_data;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = csr_data;
            end
            CSR_ROW_STRIDE: begin
               stride_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      w_eff    = clamp_dim(width_ff, MAX_W);
      h_eff    = clamp_dim(height_ff, MAX_H);
      st_clamp = clamp_dim(stride_ff, MAX_W);
      st_eff   = (st_clamp < w_eff) ? w_eff : st_clamp;
      col_ext  = {1'b0, col_ff};
      row_ext  = {1'b0, row_ff};
      row_end   = col_ext >= st_eff - ONE;
      frame_end = row_ext >= h_eff - ONE;

      pos_info.visible    = col_ext < w_eff;
      pos_info.chroma     = !col_ff[0] && !row_ff[0];
      pos_info.row_last   = col_ext == w_eff - ONE;
      pos_info.frame_last = (col_ext == w_eff - ONE) && (row_ext == h_eff - ONE);

      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + COUNT_W'(1);
         end else begin
            col_in = col_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         stride_ff <= STRIDE_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         stride_ff <= stride_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

FILE: rtl/rgb2yuv_csc.sv
// bt.601 studio range color conversion, constant weights
`timescale 1ns / 1ps

module rgb2yuv_csc
   import rgb2yuv_pkg::*;
(
   input  pixel_type    pixel,
   input  pos_info_type pos_info,
   output yuv_type      yuv
);

   localparam logic [15:0] Y_R  = 16'd65;
   localparam logic [15:0] Y_G  = 16'd129;
   localparam logic [15:0] Y_B  = 16'd25;
   localparam logic [15:0] CB_R = 16'd38;
   localparam logic [15:0] CB_G = 16'd74;
   localparam logic [15:0] C_HI = 16'd112;
   localparam logic [15:0] CR_G = 16'd94;
   localparam logic [15:0] CR_B = 16'd18;
   localparam logic [15:0] ROUND = 16'd128;
   // rounding plus the 128 offset moved ahead of the shift keeps the sums positive
   localparam logic [15:0] C_BIAS = 16'd32896;
   localparam logic [7:0]  Y_OFFSET = 8'd16;

   logic [15:0] r16, g16, b16;
   logic [15:0] y_sum, cb_sum, cr_sum;

   always_comb begin
      r16 = {8'd0, pixel.red};
      g16 = {8'd0, pixel.green};
      b16 = {8'd0, pixel.blue};

      y_sum  = r16 * Y_R + g16 * Y_G + b16 * Y_B + ROUND;
      cb_sum = b16 * C_HI + C_BIAS - (r16 * CB_R + g16 * CB_G);
      cr_sum = r16 * C_HI + C_BIAS - (g16 * CR_G + b16 * CR_B);

      yuv.luma         = y_sum[15:8] + Y_OFFSET;
      yuv.chroma_valid = pos_info.chroma;
      yuv.cb           = pos_info.chroma ? cb_sum[15:8] : 8'd0;
      yuv.cr           = pos_info.chroma ? cr_sum[15:8] : 8'd0;
      yuv.row_last     = pos_info.row_last;
      yuv.frame_last   = pos_info.frame_last;
   end

endmodule

FILE: rtl/rgb2yuv_to_yuv420_converter_placeholder.sv
// pixel input register stage with position flags
`timescale 1ns / 1ps

module rgb2yuv_in_stage
   import rgb2yuv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  logic         drain,
   input  pixel_type    pixel,
   input  pos_info_type pos_info,
   output logic         valid,
   output pixel_type    pixel_q,
   output pos_info_type pos_q
);

   logic         valid_ff, valid_in;
   pixel_type    pixel_ff;
   pos_info_type pos_ff;

   // padding pixels load a bubble
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = pos_info.visible;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel;
         pos_ff   <= pos_info;
      end
   end

   assign valid   = valid_ff;
   assign pixel_q = pixel_ff;
   assign pos_q   = pos_ff;

endmodule

FILE: rtl/rgb_to_yuv420_converter.sv
// rgb to yuv 4:2:0 converter top level
//
//  channel | direction | beat contents
//  req     | in        | one rgba pixel in raster order, alpha ignored
//  rsp     | out       | luma, optional cb/cr pair, row and frame end flags
//  csr     | in        | register index and 13-bit value
//
// one pixel per clock sustained while rsp is ready; each visible pixel gives one rsp beat
// padding pixels are taken at the same rate and give no rsp beat
// latency is set by the input register and the result register around the color math
// reset restores the default geometry and puts the position at row 0, column 0
// a stalled rsp holds the result while the input register can still take one more pixel
`timescale 1ns / 1ps

module rgb_to_yuv420_converter
   import rgb2yuv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pixel_type            req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output yuv_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   pos_info_type pos_info, s1_pos;
   pixel_type    s1_pixel;
   yuv_type      yuv;
   logic         s1_valid, s2_ready, s1_ready, req_fire, s1_move;
   logic         rsp_valid_ff, rsp_valid_in;
   yuv_type      rsp_data_ff;

   assign csr_ready = 1'b1;
   assign s2_ready  = !rsp_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid || s2_ready;
   assign req_ready = s1_ready;
   assign req_fire  = req_valid && s1_ready;
   assign s1_move   = s1_valid && s2_ready;

   rgb2yuv_pos u_pos (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .advance   (req_fire),
      .pos_info  (pos_info)
   );

   rgb2yuv_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (req_fire),
      .drain    (s1_move),
      .pixel    (req_data),
      .pos_info (pos_info),
      .valid    (s1_valid),
      .pixel_q  (s1_pixel),
      .pos_q    (s1_pos)
   );

   rgb2yuv_csc u_csc (
      .pixel    (s1_pixel),
      .pos_info (s1_pos),
      .yuv      (yuv)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= yuv;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // chroma fields are zero when no pair is carried
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.chroma_valid |-> rsp_data.cb == 8'd0 && rsp_data.cr == 8'd0)
      else $error("cb/cr nonzero without chroma_valid");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_last |-> rsp_data.row_last)
      else $error("frame_last without row_last");

   // a full input register that cannot drain must block new pixels
   assert property (@(posedge clock) disable iff (reset)
      s1_valid && !s2_ready |-> !req_ready)
      else $error("input register overrun");

   assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid)
      else $error("result lost between stages");
`endif

endmodule
